// ----- hw/rtl/pmtr_pkg.sv -----
// shared types and constants of the stereo peak meter
// field widths, item kind codes, status and length constants, the packed result word and the queue status
// depends on nothing
`default_nettype none

package pmtr_pkg;

	// widths of the word fields
	localparam int LEN_W          = 10;
	localparam int STATUS_W       = 2;
	localparam int BYTE_W         = 8;
	localparam int IN_DATA_W      = 24;
	localparam int OUT_DATA_W     = 304;
	localparam int BYTE_CNT_OUT_W = 40;
	localparam int WIN_W          = 56;

	// kind of input word, carried on tuser
	typedef enum logic {
		FUNC_HEADER = 1'b0,
		FUNC_BYTE   = 1'b1
	} func_t;

	// lowest status code that counts as an error frame
	localparam logic [STATUS_W-1:0] STATUS_ERR_MIN = 2'd2;

	// shortest length before any nonzero frame
	localparam logic [LEN_W-1:0] NONE_LEN = 10'h3FF;

	// result word, first member in the highest bits so peak16_left sits at bit 0
	typedef struct packed {
		logic [3:0]                pad;
		logic [LEN_W-1:0]          max_length;
		logic [LEN_W-1:0]          min_length;
		logic [31:0]               empty_count;
		logic [31:0]               error_count;
		logic [BYTE_CNT_OUT_W-1:0] byte_count;
		logic [31:0]               frame_count;
		logic [31:0]               peak32_right;
		logic [31:0]               peak32_left;
		logic [23:0]               peak24_right;
		logic [23:0]               peak24_left;
		logic [15:0]               peak16_right;
		logic [15:0]               peak16_left;
	} result_t;

	// result queue status seen by the update stage
	typedef struct packed {
		logic [1:0] fill;
		logic       valid;
		logic       pop;
	} qstat_t;

endpackage

`default_nettype wire

// ----- hw/rtl/pmtr_outq.sv -----
// two-entry result queue of the stereo peak meter
// decouples the update stage from the output stream handshake
// depends on pmtr_pkg
`default_nettype none

module pmtr_outq
	import pmtr_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    push,
	input  wire result_t push_data,
	input  wire logic    m_axis_tready,
	output result_t      out_data,
	output qstat_t       stat
);

	result_t    entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	logic       pop;

	assign pop = (fill_q != 2'd0) && m_axis_tready;

	// entry storage, written at the tail
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			fill_q <= fill_q + {1'b0, push} - {1'b0, pop};
		end
	end

	assign out_data   = entry_q[rd_ptr_q];
	assign stat.fill  = fill_q;
	assign stat.valid = (fill_q != 2'd0);
	assign stat.pop   = pop;

endmodule

`default_nettype wire

// ----- hw/rtl/multi_format_stereo_peak_meter_core.sv -----
// top level of the multi-format stereo peak meter
// input register, single-pass statistics update and result queue
// depends on pmtr_pkg and pmtr_outq
`default_nettype none

// Every input word (a frame header or one payload byte, told apart by tuser) gives exactly
// one result word holding the statistics after that word: per-channel absolute peaks of the
// payload read as 16-, 24- and 32-bit little-endian stereo, saturating frame, byte, error and
// empty-frame counts, and the shortest nonzero and longest frame lengths. The block takes one
// word every clock cycle when the output side keeps up; a word is registered on acceptance,
// all counters and peaks are updated from that register together, and the result enters a
// two-entry queue when the queue has room or is being read, from which the master side
// offers it. The input side keeps taking words while up to two results wait, and stalls
// only when the register and both queue entries are occupied.

module multi_format_stereo_peak_meter_core
	import pmtr_pkg::*;
#(
	parameter int MAX_LEN          = 512,
	parameter int BYTE_COUNT_WIDTH = 40
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// tdata: frame_length[9:0], frame_status[11:10], data_byte[19:12], zero[23:20]
	input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
	// tuser: func[0]
	input  wire logic [0:0]            s_axis_tuser,
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	// tdata: peak16_left, peak16_right, peak24_left, peak24_right, peak32_left, peak32_right,
	// frame_count, byte_count, error_count, empty_count, min_length, max_length, zero[303:300]
	output logic [OUT_DATA_W-1:0]      m_axis_tdata,
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready
);

	localparam logic [LEN_W-1:0]            MAX_LEN_V = LEN_W'(MAX_LEN);
	localparam logic [BYTE_COUNT_WIDTH-1:0] BYTES_MAX = '1;

	// magnitude of two's complement samples
	function automatic logic [15:0] mag16(input logic [15:0] v);
		return v[15] ? (~v + 16'd1) : v;
	endfunction

	function automatic logic [23:0] mag24(input logic [23:0] v);
		return v[23] ? (~v + 24'd1) : v;
	endfunction

	function automatic logic [31:0] mag32(input logic [31:0] v);
		return v[31] ? (~v + 32'd1) : v;
	endfunction

	function automatic logic [31:0] sat_inc32(input logic [31:0] v);
		return (v == 32'hFFFF_FFFF) ? v : (v + 32'd1);
	endfunction

	// input register
	logic                valid_s1;
	func_t               func_s1;
	logic [LEN_W-1:0]    len_s1;
	logic [STATUS_W-1:0] status_s1;
	logic [BYTE_W-1:0]   byte_s1;

	// statistics state
	logic [15:0]                 pk16l_q, pk16r_q, pk16l_d, pk16r_d;
	logic [23:0]                 pk24l_q, pk24r_q, pk24l_d, pk24r_d;
	logic [31:0]                 pk32l_q, pk32r_q, pk32l_d, pk32r_d;
	logic [31:0]                 frames_q, frames_d;
	logic [BYTE_COUNT_WIDTH-1:0] bytes_q, bytes_d;
	logic [31:0]                 errors_q, errors_d;
	logic [31:0]                 empties_q, empties_d;
	logic [LEN_W-1:0]            shortest_q, shortest_d;
	logic [LEN_W-1:0]            longest_q, longest_d;
	logic [WIN_W-1:0]            recent_q, recent_d;
	logic [LEN_W-1:0]            offset_q, offset_d;
	logic [LEN_W-1:0]            flen_q, flen_d;
	logic [2:0]                  phase6_q, phase6_d;

	// update stage signals
	logic                        s_acc;
	logic                        s1_adv;
	qstat_t                      qstat;
	result_t                     res;
	result_t                     q_data;
	logic [LEN_W-1:0]            len_c;
	logic [BYTE_COUNT_WIDTH:0]   bytes_sum;
	logic [WIN_W+BYTE_W-1:0]     win;
	logic                        byte_live;
	logic                        grp16, grp24, grp32;
	logic [15:0]                 m16l, m16r;
	logic [23:0]                 m24l, m24r;
	logic [31:0]                 m32l, m32r;
	logic [BYTE_COUNT_WIDTH+BYTE_CNT_OUT_W-1:0] bytes_ext;

	// accept while the register and queue together hold fewer than three words
	assign s_axis_tready = (({1'b0, qstat.fill} + {2'b00, valid_s1}) != 3'd3);
	assign s_acc         = s_axis_tvalid && s_axis_tready;
	assign s1_adv        = valid_s1 && ((qstat.fill != 2'd2) || qstat.pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_acc) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			func_s1   <= func_t'(s_axis_tuser[0]);
			len_s1    <= s_axis_tdata[LEN_W-1:0];
			status_s1 <= s_axis_tdata[LEN_W+STATUS_W-1:LEN_W];
			byte_s1   <= s_axis_tdata[LEN_W+STATUS_W+BYTE_W-1:LEN_W+STATUS_W];
		end
	end

	// header arithmetic
	assign len_c     = (len_s1 > MAX_LEN_V) ? MAX_LEN_V : len_s1;
	assign bytes_sum = {1'b0, bytes_q} + {{(BYTE_COUNT_WIDTH+1-LEN_W){1'b0}}, len_c};

	// byte window and group completion
	assign win       = {recent_q, byte_s1};
	assign byte_live = (offset_q < flen_q);
	assign grp16     = (offset_q[1:0] == 2'd3);
	assign grp32     = (offset_q[2:0] == 3'd7);
	assign grp24     = (phase6_q == 3'd5);

	// little-endian samples, left is the older half of the group
	assign m16l = mag16({win[23:16], win[31:24]});
	assign m16r = mag16({win[7:0], win[15:8]});
	assign m24l = mag24({win[31:24], win[39:32], win[47:40]});
	assign m24r = mag24({win[7:0], win[15:8], win[23:16]});
	assign m32l = mag32({win[39:32], win[47:40], win[55:48], win[63:56]});
	assign m32r = mag32({win[7:0], win[15:8], win[23:16], win[31:24]});

	// next state for the word in the input register
	always_comb begin
		pk16l_d    = pk16l_q;
		pk16r_d    = pk16r_q;
		pk24l_d    = pk24l_q;
		pk24r_d    = pk24r_q;
		pk32l_d    = pk32l_q;
		pk32r_d    = pk32r_q;
		frames_d   = frames_q;
		bytes_d    = bytes_q;
		errors_d   = errors_q;
		empties_d  = empties_q;
		shortest_d = shortest_q;
		longest_d  = longest_q;
		recent_d   = recent_q;
		offset_d   = offset_q;
		flen_d     = flen_q;
		phase6_d   = phase6_q;
		case (func_s1)
			FUNC_HEADER: begin
				frames_d = sat_inc32(frames_q);
				bytes_d  = bytes_sum[BYTE_COUNT_WIDTH] ? BYTES_MAX :
				           bytes_sum[BYTE_COUNT_WIDTH-1:0];
				if (status_s1 >= STATUS_ERR_MIN) begin
					errors_d = sat_inc32(errors_q);
				end
				flen_d   = len_c;
				offset_d = '0;
				recent_d = '0;
				phase6_d = 3'd0;
				if (len_c == '0) begin
					empties_d = sat_inc32(empties_q);
				end else begin
					if (len_c < shortest_q) begin
						shortest_d = len_c;
					end
					if (len_c > longest_q) begin
						longest_d = len_c;
					end
				end
			end
			FUNC_BYTE: begin
				if (byte_live) begin
					if (grp16 && (m16l > pk16l_q)) pk16l_d = m16l;
					if (grp16 && (m16r > pk16r_q)) pk16r_d = m16r;
					if (grp24 && (m24l > pk24l_q)) pk24l_d = m24l;
					if (grp24 && (m24r > pk24r_q)) pk24r_d = m24r;
					if (grp32 && (m32l > pk32l_q)) pk32l_d = m32l;
					if (grp32 && (m32r > pk32r_q)) pk32r_d = m32r;
					recent_d = win[WIN_W-1:0];
					offset_d = offset_q + 1'b1;
					phase6_d = grp24 ? 3'd0 : (phase6_q + 3'd1);
				end
			end
			default: begin
				offset_d = offset_q;
			end
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pk16l_q    <= '0;
			pk16r_q    <= '0;
			pk24l_q    <= '0;
			pk24r_q    <= '0;
			pk32l_q    <= '0;
			pk32r_q    <= '0;
			frames_q   <= '0;
			bytes_q    <= '0;
			errors_q   <= '0;
			empties_q  <= '0;
			shortest_q <= NONE_LEN;
			longest_q  <= '0;
			recent_q   <= '0;
			offset_q   <= '0;
			flen_q     <= '0;
			phase6_q   <= 3'd0;
		end else if (s1_adv) begin
			pk16l_q    <= pk16l_d;
			pk16r_q    <= pk16r_d;
			pk24l_q    <= pk24l_d;
			pk24r_q    <= pk24r_d;
			pk32l_q    <= pk32l_d;
			pk32r_q    <= pk32r_d;
			frames_q   <= frames_d;
			bytes_q    <= bytes_d;
			errors_q   <= errors_d;
			empties_q  <= empties_d;
			shortest_q <= shortest_d;
			longest_q  <= longest_d;
			recent_q   <= recent_d;
			offset_q   <= offset_d;
			flen_q     <= flen_d;
			phase6_q   <= phase6_d;
		end
	end

	// result word from the updated state
	assign bytes_ext = {{BYTE_CNT_OUT_W{1'b0}}, bytes_d};

	always_comb begin
		res              = '0;
		res.peak16_left  = pk16l_d;
		res.peak16_right = pk16r_d;
		res.peak24_left  = pk24l_d;
		res.peak24_right = pk24r_d;
		res.peak32_left  = pk32l_d;
		res.peak32_right = pk32r_d;
		res.frame_count  = frames_d;
		res.byte_count   = bytes_ext[BYTE_CNT_OUT_W-1:0];
		res.error_count  = errors_d;
		res.empty_count  = empties_d;
		res.min_length   = (longest_d == '0) ? '0 : shortest_d;
		res.max_length   = longest_d;
	end

	// result queue
	pmtr_outq u_outq (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (s1_adv),
		.push_data     (res),
		.m_axis_tready (m_axis_tready),
		.out_data      (q_data),
		.stat          (qstat)
	);

	assign m_axis_tdata  = q_data;
	assign m_axis_tvalid = qstat.valid;

`ifndef SYNTH
	// the queue never holds more than two words
	a_q_bound: assert property (@(posedge clk) disable iff (!arst_n)
		qstat.fill != 2'd3)
		else $error("result queue overflow");

	// the byte position never passes the frame length
	a_offset_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		offset_q <= flen_q)
		else $error("byte position beyond frame length");

	// once a nonzero frame is seen, the shortest length is not above the longest
	a_min_le_max: assert property (@(posedge clk) disable iff (!arst_n)
		(longest_q != '0) |-> (shortest_q <= longest_q))
		else $error("shortest length above longest length");

	// a header restarts the frame position and the 24-bit group phase
	a_header_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && (func_s1 == FUNC_HEADER)) |=> ((offset_q == '0) && (phase6_q == 3'd0)))
		else $error("header did not restart frame position");
`endif

endmodule

`default_nettype wire
